>>> rtl/pbtrb_pkg.sv
package pbtrb_pkg;

  // ring geometry
  localparam int RING_DEPTH = 64;
  localparam int BANKS      = 8;
  localparam int NWORDS     = 6;

  localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int BANK_W  = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int CNT_W   = 7;
  localparam int MEM_AW  = BANK_W + PTR_W;
  localparam int MEM_DEPTH = 2 ** MEM_AW;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [4:0]       BANK_LIMIT = 5'(BANKS);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(RING_DEPTH);

  typedef enum logic {
    OP_EMIT = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_EMIT,
    CMD_READ,
    CMD_BAD
  } cmd_kind_e;

  typedef enum logic {
    BACK_IDLE,
    BACK_STREAM
  } back_state_e;

  typedef struct packed {
    logic [15:0]                  ev_type;
    logic [63:0]                  ev_time;
    logic [30:0]                  ev_pid;
    logic [NWORDS-1:0][63:0]      ev_words;
  } event_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [BANK_W-1:0]  bank;
    logic [CNT_W-1:0]   count;
    event_t             ev;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [CNT_W-1:0]   count;
    logic               last;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage

>>> rtl/pbtrb_front.sv
module pbtrb_front
  import pbtrb_pkg::*;
(
  input  logic              start_i,
  input  logic              busy_i,
  input  logic              opcode_i,
  input  logic [3:0]        bank_i,
  input  logic [15:0]       event_type_i,
  input  logic [63:0]       timestamp_i,
  input  logic [30:0]       process_id_i,
  input  logic [63:0]       word0_i,
  input  logic [63:0]       word1_i,
  input  logic [63:0]       word2_i,
  input  logic [63:0]       word3_i,
  input  logic [63:0]       word4_i,
  input  logic [63:0]       word5_i,
  input  logic [CNT_W-1:0]  request_count_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  logic accept;
  logic bank_ok;
  logic count_ok;

  assign accept   = start_i && !busy_i;
  assign bank_ok  = {1'b0, bank_i} < BANK_LIMIT;
  assign count_ok = (request_count_i != '0) && (request_count_i <= DEPTH_CNT);

  always_comb begin
    cmd_o.bank            = bank_i[BANK_W-1:0];
    cmd_o.count           = request_count_i;
    cmd_o.ev.ev_type      = event_type_i;
    cmd_o.ev.ev_time      = timestamp_i;
    cmd_o.ev.ev_pid       = process_id_i;
    cmd_o.ev.ev_words     = {word5_i, word4_i, word3_i, word2_i, word1_i, word0_i};
    push_o                = accept;
    if (opcode_e'(opcode_i) == OP_EMIT) begin
      cmd_o.kind = CMD_EMIT;
      // emit to a missing bank is dropped here
      push_o     = accept && bank_ok;
    end else if (bank_ok && count_ok) begin
      cmd_o.kind = CMD_READ;
    end else begin
      cmd_o.kind = CMD_BAD;
    end
  end

endmodule

>>> rtl/pbtrb_queue.sv
module pbtrb_queue
  import pbtrb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  cmd_i,
  input  logic  pop_i,
  output logic  valid_o,
  output cmd_t  head_o,
  output logic  full_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  function automatic logic [QPTR_W-1:0] qnext(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + QPTR_W'(1);
    end
    return n;
  endfunction

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? qnext(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? qnext(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/pbtrb_back.sv
module pbtrb_back
  import pbtrb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    pop_o,
  output res_t    res_o,
  output event_t  ev_o
);

  back_state_e       state_q, state_d;
  logic [PTR_W-1:0]  wp_q   [BANKS];
  logic [CNT_W-1:0]  fill_q [BANKS];
  logic [BANK_W-1:0] rd_bank_q, rd_bank_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  remain_q, remain_d;
  logic [CNT_W-1:0]  rcount_q, rcount_d;
  res_t              res_q, res_d;
  logic              use_mem_q, use_mem_d;

  event_t            ev_mem [MEM_DEPTH];
  event_t            rd_data_q;

  logic              we, re;
  logic [MEM_AW-1:0] waddr, raddr;
  logic [PTR_W-1:0]  wp_sel;
  logic [CNT_W-1:0]  fill_sel;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  wp_ext;
  logic [CNT_W-1:0]  start_sum;
  logic [PTR_W-1:0]  start_ptr;

  assign wp_sel   = wp_q[cmd_i.bank];
  assign fill_sel = fill_q[cmd_i.bank];
  assign cnt      = (cmd_i.count < fill_sel) ? cmd_i.count : fill_sel;
  assign wp_ext   = CNT_W'(wp_sel);
  // oldest requested slot, modulo the ring depth
  assign start_sum = (wp_ext >= cnt) ? (wp_ext - cnt) : (wp_ext + DEPTH_CNT - cnt);
  assign start_ptr = start_sum[PTR_W-1:0];
  assign waddr     = {cmd_i.bank, wp_sel};

  always_comb begin
    state_d   = state_q;
    rd_bank_d = rd_bank_q;
    rd_ptr_d  = rd_ptr_q;
    remain_d  = remain_q;
    rcount_d  = rcount_q;
    res_d     = '{valid: 1'b0, status: ST_OK, count: '0, last: 1'b0};
    use_mem_d = 1'b0;
    pop_o     = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    raddr     = {rd_bank_q, rd_ptr_q};
    case (state_q)
      BACK_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_EMIT: begin
              we = 1'b1;
            end
            CMD_READ: begin
              if (fill_sel == '0) begin
                res_d = '{valid: 1'b1, status: ST_EMPTY, count: '0, last: 1'b1};
              end else begin
                re        = 1'b1;
                raddr     = {cmd_i.bank, start_ptr};
                rd_bank_d = cmd_i.bank;
                rd_ptr_d  = ptr_next(start_ptr);
                remain_d  = cnt - CNT_W'(1);
                rcount_d  = cnt;
                use_mem_d = 1'b1;
                res_d     = '{valid: 1'b1, status: ST_OK, count: cnt,
                              last: (cnt == CNT_W'(1))};
                if (cnt != CNT_W'(1)) begin
                  state_d = BACK_STREAM;
                end
              end
            end
            default: begin
              res_d = '{valid: 1'b1, status: ST_INVALID, count: '0, last: 1'b1};
            end
          endcase
        end
      end
      BACK_STREAM: begin
        re        = 1'b1;
        rd_ptr_d  = ptr_next(rd_ptr_q);
        remain_d  = remain_q - CNT_W'(1);
        use_mem_d = 1'b1;
        res_d     = '{valid: 1'b1, status: ST_OK, count: rcount_q,
                      last: (remain_q == CNT_W'(1))};
        if (remain_q == CNT_W'(1)) begin
          state_d = BACK_IDLE;
        end
      end
      default: begin
        state_d = BACK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BACK_IDLE;
      res_q     <= '{valid: 1'b0, status: ST_OK, count: '0, last: 1'b0};
      use_mem_q <= 1'b0;
      rd_bank_q <= '0;
      rd_ptr_q  <= '0;
      remain_q  <= '0;
      rcount_q  <= '0;
      for (int b = 0; b < BANKS; b++) begin
        wp_q[b]   <= '0;
        fill_q[b] <= '0;
      end
    end else begin
      state_q   <= state_d;
      res_q     <= res_d;
      use_mem_q <= use_mem_d;
      rd_bank_q <= rd_bank_d;
      rd_ptr_q  <= rd_ptr_d;
      remain_q  <= remain_d;
      rcount_q  <= rcount_d;
      if (we) begin
        wp_q[cmd_i.bank] <= ptr_next(wp_sel);
        if (fill_sel < DEPTH_CNT) begin
          fill_q[cmd_i.bank] <= fill_sel + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      ev_mem[waddr] <= cmd_i.ev;
    end
    if (re) begin
      rd_data_q <= ev_mem[raddr];
    end
  end

  assign res_o = res_q;
  assign ev_o  = use_mem_q ? rd_data_q : '0;

endmodule

>>> rtl/per_bank_trace_ring_buffer_core.sv
// per-bank trace ring buffer: one overwriting ring of trace events per bank
//
// request channel: a request is taken at a rising edge with start_i high and
// busy_o low. opcode 0 stores an event at the bank's write pointer and gives
// no result; opcode 1 asks for the newest request_count events of a bank.
// result channel: result_valid_o marks one result for exactly one cycle; the
// receiver cannot hold it off. a read gives min(request_count, fill) results,
// oldest first, each with copied_count and last on the final one; a bad bank
// or count gives one status-1 result, an empty ring one status-2 result.
// throughput: emits sustain one per cycle. a read holds the back end until
// it has returned its events (or its error or empty result), since the
// event memory has a single read port; requests queue up behind it in a
// two-entry command queue and busy_o rises when that queue is full.
// path: with the queue empty, the first result of a read goes through the
// queue, then the registered memory read, to the ports; the rest follow one
// per cycle.
// reset: write pointers, fill counts and the queue clear; event storage is
// left as is and only slots written since reset are ever read back.
module per_bank_trace_ring_buffer_core
  import pbtrb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              opcode_i,
  input  logic [3:0]        bank_i,
  input  logic [15:0]       event_type_i,
  input  logic [63:0]       timestamp_i,
  input  logic [30:0]       process_id_i,
  input  logic [63:0]       word0_i,
  input  logic [63:0]       word1_i,
  input  logic [63:0]       word2_i,
  input  logic [63:0]       word3_i,
  input  logic [63:0]       word4_i,
  input  logic [63:0]       word5_i,
  input  logic [6:0]        request_count_i,
  output logic              result_valid_o,
  output logic [1:0]        status_o,
  output logic [15:0]       out_type_o,
  output logic [63:0]       out_time_o,
  output logic [30:0]       out_pid_o,
  output logic [63:0]       out_word0_o,
  output logic [63:0]       out_word1_o,
  output logic [63:0]       out_word2_o,
  output logic [63:0]       out_word3_o,
  output logic [63:0]       out_word4_o,
  output logic [63:0]       out_word5_o,
  output logic [6:0]        copied_count_o,
  output logic              last_o
);

  // front to queue
  logic   push;
  cmd_t   front_cmd;
  // queue to back
  logic   q_valid;
  logic   q_full;
  logic   pop;
  cmd_t   head_cmd;
  // back to result ports
  res_t   res;
  event_t ev;

  // busy whenever the command queue cannot take another request
  assign busy_o = q_full;

  pbtrb_front u_front (
    .start_i         (start_i),
    .busy_i          (q_full),
    .opcode_i        (opcode_i),
    .bank_i          (bank_i),
    .event_type_i    (event_type_i),
    .timestamp_i     (timestamp_i),
    .process_id_i    (process_id_i),
    .word0_i         (word0_i),
    .word1_i         (word1_i),
    .word2_i         (word2_i),
    .word3_i         (word3_i),
    .word4_i         (word4_i),
    .word5_i         (word5_i),
    .request_count_i (request_count_i),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  pbtrb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head_cmd),
    .full_o  (q_full)
  );

  // back end owns pointers, fill counts and the event memory
  pbtrb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .res_o       (res),
    .ev_o        (ev)
  );

  assign result_valid_o = res.valid;
  assign status_o       = res.status;
  assign copied_count_o = res.count;
  assign last_o         = res.last;
  // event fields read as zero on error and empty results
  assign out_type_o     = ev.ev_type;
  assign out_time_o     = ev.ev_time;
  assign out_pid_o      = ev.ev_pid;
  assign out_word0_o    = ev.ev_words[0];
  assign out_word1_o    = ev.ev_words[1];
  assign out_word2_o    = ev.ev_words[2];
  assign out_word3_o    = ev.ev_words[3];
  assign out_word4_o    = ev.ev_words[4];
  assign out_word5_o    = ev.ev_words[5];

endmodule

>>> test/trace_ring_checker.sv
module trace_ring_checker
  import pbtrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        opcode_i,
  input  logic [3:0]  bank_i,
  input  logic [15:0] event_type_i,
  input  logic [63:0] timestamp_i,
  input  logic [30:0] process_id_i,
  input  logic [63:0] word0_i,
  input  logic [63:0] word1_i,
  input  logic [63:0] word2_i,
  input  logic [63:0] word3_i,
  input  logic [63:0] word4_i,
  input  logic [63:0] word5_i,
  input  logic [6:0]  request_count_i,
  input  logic        result_valid_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] out_type_i,
  input  logic [63:0] out_time_i,
  input  logic [30:0] out_pid_i,
  input  logic [63:0] out_word0_i,
  input  logic [63:0] out_word1_i,
  input  logic [63:0] out_word2_i,
  input  logic [63:0] out_word3_i,
  input  logic [63:0] out_word4_i,
  input  logic [63:0] out_word5_i,
  input  logic [6:0]  copied_count_i,
  input  logic        last_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0]        ev_type;
    logic [63:0]        ev_time;
    logic [30:0]        ev_pid;
    logic [5:0][63:0]   ev_words;
  } trace_event_t;

  typedef struct packed {
    status_e            status;
    trace_event_t       ev;
    logic [6:0]         count;
    logic               last;
  } readout_t;

  // shadow of the rings
  trace_event_t ring_events[BANKS][RING_DEPTH];
  int           wr_ptr[BANKS];
  int           fill[BANKS];
  readout_t     readout_q[$];
  int           mismatches = 0;

  initial begin
    for (int b = 0; b < BANKS; b++) begin
      wr_ptr[b] = 0;
      fill[b]   = 0;
    end
  end

  assign mismatch_count_o = mismatches;

  function automatic readout_t status_only(status_e st);
    readout_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // apply one accepted request to the shadow state, queue what it returns
  task automatic track_request();
    int       b;
    int       n;
    int       cnt;
    int       first;
    readout_t r;
    b = int'(bank_i);
    n = int'(request_count_i);
    if (opcode_i == OP_EMIT) begin
      if (b < BANKS) begin
        ring_events[b][wr_ptr[b]] = '{event_type_i, timestamp_i, process_id_i,
                                      {word5_i, word4_i, word3_i, word2_i,
                                       word1_i, word0_i}};
        wr_ptr[b] = (wr_ptr[b] + 1) % RING_DEPTH;
        if (fill[b] < RING_DEPTH) fill[b]++;
      end
    end else if (b >= BANKS || n == 0 || n > RING_DEPTH) begin
      readout_q.push_back(status_only(ST_INVALID));
    end else if (fill[b] == 0) begin
      readout_q.push_back(status_only(ST_EMPTY));
    end else begin
      cnt   = (n < fill[b]) ? n : fill[b];
      first = (wr_ptr[b] + RING_DEPTH - cnt) % RING_DEPTH;
      for (int k = 0; k < cnt; k++) begin
        r.status = ST_OK;
        r.ev     = ring_events[b][(first + k) % RING_DEPTH];
        r.count  = 7'(cnt);
        r.last   = (k == cnt - 1);
        readout_q.push_back(r);
      end
    end
  endtask

  task automatic compare_field(string name, logic [63:0] exp, logic [63:0] got);
    if (exp !== got) begin
      $error("%s: expected %h, got %h", name, exp, got);
      mismatches++;
    end
  endtask

  task automatic check_readout();
    readout_t         exp;
    logic [5:0][63:0] got_words;
    got_words = {out_word5_i, out_word4_i, out_word3_i, out_word2_i,
                 out_word1_i, out_word0_i};
    if (readout_q.size() == 0) begin
      $error("result with no pending request");
      mismatches++;
    end else begin
      exp = readout_q.pop_front();
      compare_field("status", 64'(exp.status), 64'(status_i));
      compare_field("out_type", 64'(exp.ev.ev_type), 64'(out_type_i));
      compare_field("out_time", exp.ev.ev_time, out_time_i);
      compare_field("out_pid", 64'(exp.ev.ev_pid), 64'(out_pid_i));
      for (int k = 0; k < 6; k++) begin
        compare_field($sformatf("out_word%0d", k), exp.ev.ev_words[k], got_words[k]);
      end
      compare_field("copied_count", 64'(exp.count), 64'(copied_count_i));
      compare_field("last", 64'(exp.last), 64'(last_i));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_i === 1'b1) check_readout();
      if (start_i && !busy_i) track_request();
    end
    pending_o <= readout_q.size();
  end

endmodule

>>> test/testbench.sv
module testbench;
  import pbtrb_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 100;
  localparam int HOT_BANK     = BANKS - 1;

  // one request as the sender sees it
  typedef struct packed {
    opcode_e          op;
    logic [3:0]       bank;
    logic [15:0]      ev_type;
    logic [63:0]      ev_time;
    logic [30:0]      pid;
    logic [5:0][63:0] words;
    logic [6:0]       n;
  } trace_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        opcode_i;
  logic [3:0]  bank_i;
  logic [15:0] event_type_i;
  logic [63:0] timestamp_i;
  logic [30:0] process_id_i;
  logic [63:0] word0_i, word1_i, word2_i, word3_i, word4_i, word5_i;
  logic [6:0]  request_count_i;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [15:0] out_type_o;
  logic [63:0] out_time_o;
  logic [30:0] out_pid_o;
  logic [63:0] out_word0_o, out_word1_o, out_word2_o;
  logic [63:0] out_word3_o, out_word4_o, out_word5_o;
  logic [6:0]  copied_count_o;
  logic        last_o;

  int mismatch_count;
  int pending;
  int cycle_count = 0;

  always #5 clk_i = ~clk_i;

  per_bank_trace_ring_buffer_core dut (.*);

  trace_ring_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .opcode_i        (opcode_i),
    .bank_i          (bank_i),
    .event_type_i    (event_type_i),
    .timestamp_i     (timestamp_i),
    .process_id_i    (process_id_i),
    .word0_i         (word0_i),
    .word1_i         (word1_i),
    .word2_i         (word2_i),
    .word3_i         (word3_i),
    .word4_i         (word4_i),
    .word5_i         (word5_i),
    .request_count_i (request_count_i),
    .result_valid_i  (result_valid_o),
    .status_i        (status_o),
    .out_type_i      (out_type_o),
    .out_time_i      (out_time_o),
    .out_pid_i       (out_pid_o),
    .out_word0_i     (out_word0_o),
    .out_word1_i     (out_word1_o),
    .out_word2_i     (out_word2_o),
    .out_word3_i     (out_word3_o),
    .out_word4_i     (out_word4_o),
    .out_word5_i     (out_word5_o),
    .copied_count_i  (copied_count_o),
    .last_i          (last_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  // watchdog: a hung block or a lost result ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // emit with every payload field filled from one pattern
  function automatic trace_req_t emit_req(logic [3:0] bank, logic [63:0] pattern);
    trace_req_t r;
    r.op      = OP_EMIT;
    r.bank    = bank;
    r.ev_type = pattern[15:0];
    r.ev_time = pattern;
    r.pid     = pattern[30:0];
    for (int k = 0; k < 6; k++) r.words[k] = pattern;
    r.n       = pattern[6:0];
    return r;
  endfunction

  function automatic trace_req_t read_req(logic [3:0] bank, logic [6:0] n);
    trace_req_t r;
    r      = emit_req(bank, 64'h0);
    r.op   = OP_READ;
    r.n    = n;
    return r;
  endfunction

  // random request: mostly emits, over half piled onto one hot bank, with a
  // sprinkling of bad banks and bad counts
  function automatic trace_req_t random_req();
    trace_req_t r;
    int         pick;
    r.op      = ($urandom_range(0, 3) == 0) ? OP_READ : OP_EMIT;
    pick      = $urandom_range(0, 99);
    if (pick < 55) r.bank = 4'(HOT_BANK);
    else if (pick < 90) r.bank = 4'($urandom_range(0, BANKS - 1));
    else r.bank = 4'($urandom_range(BANKS, 15));
    r.ev_type = 16'($urandom);
    r.ev_time = {$urandom, $urandom};
    r.pid     = 31'($urandom);
    for (int k = 0; k < 6; k++) r.words[k] = {$urandom, $urandom};
    pick      = $urandom_range(0, 99);
    if (r.op == OP_EMIT) r.n = 7'($urandom_range(0, 127));
    else if (pick < 40) r.n = 7'($urandom_range(1, RING_DEPTH));
    else if (pick < 60) r.n = 7'(RING_DEPTH);
    else if (pick < 85) r.n = 7'($urandom_range(1, 4));
    else if (pick < 92) r.n = 7'd0;
    else r.n = 7'($urandom_range(RING_DEPTH + 1, 127));
    return r;
  endfunction

  // mostly back to back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive a request and hold it until the block takes it
  task automatic issue(trace_req_t r);
    start_i         <= 1'b1;
    opcode_i        <= r.op;
    bank_i          <= r.bank;
    event_type_i    <= r.ev_type;
    timestamp_i     <= r.ev_time;
    process_id_i    <= r.pid;
    word0_i         <= r.words[0];
    word1_i         <= r.words[1];
    word2_i         <= r.words[2];
    word3_i         <= r.words[3];
    word4_i         <= r.words[4];
    word5_i         <= r.words[5];
    request_count_i <= r.n;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // hold off until every queued result has come out
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    opcode_i        = 1'b0;
    bank_i          = '0;
    event_type_i    = '0;
    timestamp_i     = '0;
    process_id_i    = '0;
    word0_i         = '0;
    word1_i         = '0;
    word2_i         = '0;
    word3_i         = '0;
    word4_i         = '0;
    word5_i         = '0;
    request_count_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: error and empty reads on fresh rings
    issue(read_req(4'd0, 7'd1));                    // empty ring
    issue(read_req(4'd15, 7'd5));                   // bank far out of range
    issue(read_req(4'(BANKS), 7'(RING_DEPTH)));     // first bank past the end
    issue(read_req(4'd0, 7'd0));                    // zero count
    issue(read_req(4'd0, 7'(RING_DEPTH + 1)));      // count just past depth
    issue(read_req(4'd0, 7'd127));                  // largest count field
    issue(emit_req(4'd9, {64{1'b1}}));              // emit to bad bank, dropped
    issue(read_req(4'd1, 7'd1));                    // still empty after that
    // directed: field extremes stored and read back
    issue(emit_req(4'd0, {64{1'b1}}));
    issue(emit_req(4'd0, 64'h0));
    issue(emit_req(4'(HOT_BANK), {64{1'b1}}));
    issue(emit_req(4'(HOT_BANK), 64'h5a5a_a5a5_0f0f_f0f0));
    issue(emit_req(4'd0, 64'hdead_beef_0123_4567));
    issue(read_req(4'd0, 7'(RING_DEPTH)));          // ask more than held
    issue(read_req(4'd0, 7'd1));                    // newest only
    issue(read_req(4'(HOT_BANK), 7'd2));            // exact fill
    issue(read_req(4'd3, 7'(RING_DEPTH)));          // untouched bank
    pause(3);
    issue(emit_req(4'd15, 64'h0));
    issue(read_req(4'd0, 7'd2));
    drain();

    // random: alternate stretches with and without sender pauses
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      issue(random_req());
      if ((i / 20) % 2 == 1) pause(pick_gap());
      if (i == RANDOM_ITEMS / 2) drain();
    end

    // sweep every bank, full depth, to read back each ring's contents
    for (int b = 0; b < BANKS; b++) begin
      issue(read_req(4'(b), 7'(RING_DEPTH)));
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
